### design/double_ended_queue_assert.svh
// ------------------------------------------------------------------------
// double_ended_queue assertion macros
// shared concurrent assertion forms, sampled on clk, off during reset
// ------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// same-cycle implication
`define DEQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DEQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/deq_pkg.sv
// ------------------------------------------------------------------------
// deq_pkg
// types and codes shared by the double-ended queue modules
// ------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

    localparam int WORD_W  = 32;
    localparam int COUNT_W = 5;

    typedef logic [1:0]         op_t;
    typedef logic [1:0]         status_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [WORD_W-1:0]  word_t;

    localparam op_t OP_PUSH_FRONT = 2'd0;
    localparam op_t OP_PUSH_REAR  = 2'd1;
    localparam op_t OP_POP_FRONT  = 2'd2;
    localparam op_t OP_POP_REAR   = 2'd3;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

    typedef struct packed {
        op_t                      op;
        logic signed [WORD_W-1:0] value;
    } in_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] popped_value;
        status_t                  status;
        count_t                   entry_count;
    } out_t;

    // controller to datapath
    typedef struct packed {
        logic accept;   // input beat taken: update ring, issue ram access
        logic load;     // result register takes the formed result
    } ctrl_cmd_t;

endpackage

`default_nettype wire

### design/double_ended_queue.sv
// ------------------------------------------------------------------------
// double_ended_queue
// double-ended queue of signed words in a ring ram, push/pop at both ends
// ------------------------------------------------------------------------
//  channel  | signals                     | payload
//  ---------+-----------------------------+-------------------------------
//  in       | in_valid / in_ready         | in_data  (op, value)
//  out      | out_valid / out_ready       | out_data (popped_value, status,
//           |                             |           entry_count)
//
//  each operation first updates the ring indices and accesses the entry
//  ram, then forms the result from the registered ram read
//  a new operation is taken while the previous result waits in the output
//  register; the block stalls only when that register is still held
//  reset clears the front index, the count and the handshake state; the
//  entry ram is not cleared
// ------------------------------------------------------------------------
`default_nettype none

module double_ended_queue #(
    parameter int DEPTH = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire deq_pkg::in_t  in_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output deq_pkg::out_t      out_data
);

    deq_pkg::ctrl_cmd_t cmd;

    deq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    deq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_data  (in_data),
        .out_data (out_data)
    );

endmodule

`default_nettype wire

### design/deq_ram.sv
// ------------------------------------------------------------------------
// deq_ram
// generic single-write, single-read ram with registered read data
// ------------------------------------------------------------------------
`default_nettype none

module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        // read data holds until the next read
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### design/deq_datapath.sv
// ------------------------------------------------------------------------
// deq_datapath
// ring indices, entry count, entry ram and result register
// ------------------------------------------------------------------------
`default_nettype none

module deq_datapath #(
    parameter int DEPTH = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire deq_pkg::ctrl_cmd_t cmd,
    input  wire deq_pkg::in_t      in_data,
    output deq_pkg::out_t          out_data
);

    `include "double_ended_queue_assert.svh"

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = IW + 1;

    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
    localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [IW-1:0] front_reg, front_next;
    logic [CW-1:0] count_reg, count_next;
    deq_pkg::status_t status_reg, status_next;
    logic          pop_ok_reg, pop_ok_next;
    deq_pkg::out_t out_reg, out_next;

    logic          is_push;
    logic          full;
    logic          empty;
    logic [IW-1:0] front_dec;
    logic [IW-1:0] front_inc;
    logic [SW-1:0] rear_sum;
    logic [SW-1:0] rear_last_sum;
    logic [IW-1:0] rear_free;
    logic [IW-1:0] rear_last;

    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    deq_pkg::word_t rd_data;

    assign is_push = (in_data.op == deq_pkg::OP_PUSH_FRONT) ||
                     (in_data.op == deq_pkg::OP_PUSH_REAR);
    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);

    // ring arithmetic, all sums stay below twice the depth
    assign front_dec     = (front_reg == '0) ? LAST_IDX : front_reg - 1'b1;
    assign front_inc     = (front_reg == LAST_IDX) ? '0 : front_reg + 1'b1;
    assign rear_sum      = {1'b0, front_reg} + SW'(count_reg);
    assign rear_last_sum = rear_sum - 1'b1;
    assign rear_free     = (rear_sum >= DEPTH_S) ? IW'(rear_sum - DEPTH_S)
                                                 : IW'(rear_sum);
    assign rear_last     = (rear_last_sum >= DEPTH_S) ? IW'(rear_last_sum - DEPTH_S)
                                                      : IW'(rear_last_sum);

    always_comb
    begin
        front_next  = front_reg;
        count_next  = count_reg;
        status_next = status_reg;
        pop_ok_next = pop_ok_reg;
        wr_en       = 1'b0;
        wr_addr     = rear_free;
        rd_en       = 1'b0;
        rd_addr     = front_reg;
        if (cmd.accept)
        begin
            status_next = deq_pkg::ST_OK;
            pop_ok_next = 1'b0;
            if (is_push)
            begin
                if (full)
                begin
                    status_next = deq_pkg::ST_FULL;
                end
                else
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                    if (in_data.op == deq_pkg::OP_PUSH_FRONT)
                    begin
                        wr_addr    = front_dec;
                        front_next = front_dec;
                    end
                end
            end
            else
            begin
                if (empty)
                begin
                    status_next = deq_pkg::ST_EMPTY;
                end
                else
                begin
                    rd_en       = 1'b1;
                    pop_ok_next = 1'b1;
                    count_next  = count_reg - 1'b1;
                    if (in_data.op == deq_pkg::OP_POP_FRONT)
                    begin
                        front_next = front_inc;
                    end
                    else
                    begin
                        rd_addr = rear_last;
                    end
                end
            end
        end
    end

    always_comb
    begin
        out_next = out_reg;
        if (cmd.load)
        begin
            out_next.popped_value = pop_ok_reg ? $signed(rd_data) : '0;
            out_next.status       = status_reg;
            out_next.entry_count  = deq_pkg::count_t'(count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        pop_ok_reg <= pop_ok_next;
        out_reg    <= out_next;
    end

    deq_ram #(
        .WIDTH (deq_pkg::WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (in_data.value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_data = out_reg;

    `DEQ_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= FULL_CNT, "entry count above depth")
    `DEQ_ASSERT_NOW(a_one_access, 1'b1, !(wr_en && rd_en), "ram read and write together")
    `DEQ_ASSERT_NEXT(a_full_drop, cmd.accept && is_push && full, (status_reg == deq_pkg::ST_FULL) && $stable(count_reg) && $stable(front_reg), "push on full queue changed state")

endmodule

`default_nettype wire

### design/deq_ctrl.sv
// ------------------------------------------------------------------------
// deq_ctrl
// sequences one operation at a time and owns the output valid flag
// ------------------------------------------------------------------------
`default_nettype none

module deq_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output deq_pkg::ctrl_cmd_t      cmd
);

    `include "double_ended_queue_assert.svh"

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_FORM = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    assign in_ready   = (state_reg == ST_IDLE);
    assign cmd.accept = in_valid && in_ready;
    // result register is free, or its beat leaves this cycle
    assign cmd.load   = (state_reg == ST_FORM) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.accept)
                begin
                    state_next = ST_FORM;
                end
            end
            ST_FORM:
            begin
                if (cmd.load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `DEQ_ASSERT_NEXT(a_accept_forms, cmd.accept, (state_reg == ST_FORM) && !in_ready, "accepted beat did not start forming")
    `DEQ_ASSERT_NEXT(a_load_shows, cmd.load, out_valid_reg && in_ready, "formed result not presented")
    `DEQ_ASSERT_NOW(a_no_overwrite, cmd.load && out_valid_reg, out_ready, "result register overwritten")

endmodule

`default_nettype wire

### bench/deq_checker.sv
// ------------------------------------------------------------------------
// deq_checker
// watches both channels of the double-ended queue, keeps its own ring
// image to predict every result beat and compares them in order
// ------------------------------------------------------------------------
module deq_checker #(
    parameter int DEPTH = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_ready,
    input  deq_pkg::in_t  in_data,
    input  logic          out_valid,
    input  logic          out_ready,
    input  deq_pkg::out_t out_data,
    output int            mismatches,
    output int            waiting,
    output int            op_beats,
    output int            result_beats,
    output int            full_drops,
    output int            empty_pops,
    output int            peak_fill
);
    timeunit 1ns;
    timeprecision 1ps;

    deq_pkg::word_t ring_words [DEPTH];
    int             head_idx;
    int             held;
    deq_pkg::out_t  pending_results [$];
    deq_pkg::out_t  want;

    // apply one operation to the ring image and form its result
    function automatic deq_pkg::out_t deque_apply(deq_pkg::in_t beat);
        deq_pkg::out_t res;
        int            slot;
        res = '0;
        res.status = deq_pkg::ST_OK;
        if (beat.op == deq_pkg::OP_PUSH_FRONT || beat.op == deq_pkg::OP_PUSH_REAR)
        begin
            if (held >= DEPTH)
            begin
                res.status = deq_pkg::ST_FULL;
            end
            else if (beat.op == deq_pkg::OP_PUSH_FRONT)
            begin
                head_idx = (head_idx + DEPTH - 1) % DEPTH;
                ring_words[head_idx] = beat.value;
                held++;
            end
            else
            begin
                slot = (head_idx + held) % DEPTH;
                ring_words[slot] = beat.value;
                held++;
            end
        end
        else
        begin
            if (held == 0)
            begin
                res.status = deq_pkg::ST_EMPTY;
            end
            else if (beat.op == deq_pkg::OP_POP_FRONT)
            begin
                res.popped_value = ring_words[head_idx];
                head_idx = (head_idx + 1) % DEPTH;
                held--;
            end
            else
            begin
                slot = (head_idx + held - 1) % DEPTH;
                res.popped_value = ring_words[slot];
                held--;
            end
        end
        res.entry_count = deq_pkg::count_t'(held);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_idx     = 0;
            held         = 0;
            pending_results.delete();
            mismatches   = 0;
            waiting      = 0;
            op_beats     = 0;
            result_beats = 0;
            full_drops   = 0;
            empty_pops   = 0;
            peak_fill    = 0;
            foreach (ring_words[i]) ring_words[i] = '0;
        end
        else
        begin
            // result beat first: it always belongs to an older operation
            if (out_valid && out_ready)
            begin
                result_beats++;
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t deque: result beat with nothing pending: %s %0d %0d %0d",
                                 $realtime, "value/status/count",
                                 out_data.popped_value, out_data.status,
                                 out_data.entry_count);
                end
                else
                begin
                    want = pending_results[0];
                    pending_results.delete(0);
                    if (out_data.popped_value !== want.popped_value
                        || out_data.status !== want.status
                        || out_data.entry_count !== want.entry_count)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("%0t deque mismatch: want value %0d status %0d count %0d",
                                     $realtime, want.popped_value, want.status,
                                     want.entry_count);
                            $display("    got value %0d status %0d count %0d",
                                     out_data.popped_value, out_data.status,
                                     out_data.entry_count);
                        end
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                op_beats++;
                want = deque_apply(in_data);
                pending_results.push_back(want);
                if (want.status == deq_pkg::ST_FULL)
                    full_drops++;
                if (want.status == deq_pkg::ST_EMPTY)
                    empty_pops++;
                if (held > peak_fill)
                    peak_fill = held;
            end
            waiting = pending_results.size();
        end
    end

endmodule

### bench/tb_double_ended_queue.sv
// ------------------------------------------------------------------------
// tb_double_ended_queue
// drives push and pop operations at both ends of the queue with random
// gaps on both channels; a directed opening covers the empty and full
// corners, then push-heavy, pop-heavy and balanced phases sweep the fill level
// ------------------------------------------------------------------------
module tb_double_ended_queue;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUEUE_DEPTH = 16;
    localparam int RANDOM_OPS  = 1776;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 300;
    localparam int DRAIN_WAIT  = 10;

    localparam deq_pkg::word_t FILL_WORDS [QUEUE_DEPTH] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
        32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFE,
        32'h1234_5678, 32'hEDCB_A987, 32'h0F0F_0F0F, 32'hF0F0_F0F0,
        32'h3333_3333, 32'hCCCC_CCCC, 32'h00FF_00FF, 32'hFF00_FF00
    };
    localparam deq_pkg::word_t EDGE_WORDS [4] = '{
        32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF
    };

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_ready;
    deq_pkg::in_t  in_data;
    logic          out_valid;
    logic          out_ready;
    deq_pkg::out_t out_data;

    int mismatches;
    int waiting;
    int op_beats;
    int result_beats;
    int full_drops;
    int empty_pops;
    int peak_fill;

    int send_run_left;
    int hold_rounds;

    double_ended_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    deq_checker #(
        .DEPTH(QUEUE_DEPTH)
    ) checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data),
        .mismatches   (mismatches),
        .waiting      (waiting),
        .op_beats     (op_beats),
        .result_beats (result_beats),
        .full_drops   (full_drops),
        .empty_pops   (empty_pops),
        .peak_fill    (peak_fill)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles, %0d results still pending",
                 CYCLE_LIMIT, waiting);
        $display("tb_double_ended_queue: errors");
        $finish;
    end

    // called at a falling edge, returns at the falling edge after the beat
    task automatic send_op(input deq_pkg::op_t op, input deq_pkg::word_t value);
        int gap;
        if (send_run_left > 0)
        begin
            send_run_left--;
            gap = 0;
        end
        else if ($urandom_range(0, 15) == 0)
        begin
            send_run_left = $urandom_range(10, 40);
            gap = 0;
        end
        else
        begin
            gap = $urandom_range(0, 13);
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data.op    <= op;
        in_data.value <= value;
        in_valid      <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // sender
    initial
    begin
        int             phase_left;
        int             push_pct;
        deq_pkg::op_t   op;
        deq_pkg::word_t value;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        send_run_left = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty corners, single-entry round trips at both ends
        send_op(deq_pkg::OP_POP_FRONT, 32'h0);
        send_op(deq_pkg::OP_POP_REAR, 32'h0);
        send_op(deq_pkg::OP_PUSH_FRONT, 32'h7FFF_FFFF);
        send_op(deq_pkg::OP_POP_REAR, 32'h0);
        send_op(deq_pkg::OP_PUSH_REAR, 32'h8000_0000);
        send_op(deq_pkg::OP_POP_FRONT, 32'hFFFF_FFFF);
        // fill from both ends, then push into a full queue at both ends
        for (int i = 0; i < QUEUE_DEPTH; i++)
            send_op(i[0] ? deq_pkg::OP_PUSH_REAR : deq_pkg::OP_PUSH_FRONT, FILL_WORDS[i]);
        send_op(deq_pkg::OP_PUSH_FRONT, 32'h1111_1111);
        send_op(deq_pkg::OP_PUSH_REAR, 32'hEEEE_EEEE);

        // phases lean toward pushes or pops, or stay balanced, to sweep between empty and full
        phase_left = 0;
        push_pct   = 50;
        for (int n = 0; n < RANDOM_OPS; n++)
        begin
            if (phase_left == 0)
            begin
                phase_left = $urandom_range(20, 80);
                case ($urandom_range(0, 4))
                    0: push_pct = 85;
                    1: push_pct = 15;
                    2: push_pct = 70;
                    3: push_pct = 30;
                    default: push_pct = 50;
                endcase
            end
            phase_left--;
            if ($urandom_range(0, 99) < push_pct)
                op = $urandom_range(0, 1) ? deq_pkg::OP_PUSH_REAR : deq_pkg::OP_PUSH_FRONT;
            else
                op = $urandom_range(0, 1) ? deq_pkg::OP_POP_REAR : deq_pkg::OP_POP_FRONT;
            if ($urandom_range(0, 7) == 0)
                value = EDGE_WORDS[$urandom_range(0, 3)];
            else
                value = $urandom;
            send_op(op, value);
        end
        in_valid <= 1'b0;

        while (waiting != 0) @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);

        $display("covered %0d operations and %0d results, fill peaked at %0d of %0d",
                 op_beats, result_beats, peak_fill, QUEUE_DEPTH);
        $display("saw %0d pushes refused while full, %0d pops on empty, %0d long stalls",
                 full_drops, empty_pops, hold_rounds);
        if (mismatches == 0 && waiting == 0)
            $display("tb_double_ended_queue: clean");
        else
            $display("tb_double_ended_queue: errors");
        $finish;
    end

    // receiver
    initial
    begin
        int gap;
        int run_left;
        out_ready   = 1'b0;
        hold_rounds = 0;
        run_left    = 0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            // long hold-off lets the output back up and stall the input side
            if (hold_rounds < 2 && result_beats >= 300 + 700 * hold_rounds)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_rounds++;
            end
            if (run_left > 0)
            begin
                run_left--;
                gap = 0;
            end
            else if ($urandom_range(0, 15) == 0)
            begin
                run_left = $urandom_range(10, 40);
                gap = 0;
            end
            else
            begin
                gap = $urandom_range(0, 13);
            end
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            @(negedge clk);
        end
    end

endmodule
